// File: design/fnm_pkg.sv
// fnm_pkg: shared types, register codes and the note frequency rom
`timescale 1ns / 1ps

package fnm_pkg;

  // field widths
  localparam int unsigned FREQ_W      = 17;
  localparam int unsigned NTOL_W      = 12;
  localparam int unsigned MTOL_W      = 16;
  localparam int unsigned OCT_W       = 4;
  localparam int unsigned NOTE_W      = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned PROD_W      = 2 * FREQ_W;

  // rom geometry
  localparam int unsigned ROM_LEN     = 97;
  localparam int unsigned ROM_IDX_W   = $clog2(ROM_LEN);
  localparam logic [NOTE_W-1:0] NOTES_PER_OCTAVE = NOTE_W'(12);
  localparam logic [NOTE_W-1:0] LAST_NOTE        = NOTE_W'(11);

  // match test scales the best difference by 2^16
  localparam logic [FREQ_W-1:0] MTOL_SCALE = FREQ_W'(65536);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_CTR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_TOL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOL  = 3'd4;

  // register reset values
  localparam logic [FREQ_W-1:0] MIN_FREQ_RST  = 17'd440;
  localparam logic [FREQ_W-1:0] MAX_FREQ_RST  = 17'd66976;
  localparam logic [FREQ_W-1:0] NOISE_CTR_RST = 17'd640;
  localparam logic [NTOL_W-1:0] NOISE_TOL_RST = 12'd32;
  localparam logic [MTOL_W-1:0] MATCH_TOL_RST = 16'd6554;

  // operands of the shared cross-multiply unit
  typedef struct packed {
    logic [FREQ_W-1:0] a0;
    logic [FREQ_W-1:0] b0;
    logic [FREQ_W-1:0] a1;
    logic [FREQ_W-1:0] b1;
  } mul_ops_t;

  // note frequencies C0 upward in semitones, 1/16 Hz units
  localparam logic [FREQ_W-1:0] NOTE_ROM [ROM_LEN] = '{
    17'd262,   17'd277,   17'd294,   17'd311,   17'd330,   17'd349,
    17'd370,   17'd392,   17'd415,   17'd440,   17'd466,   17'd494,
    17'd523,   17'd554,   17'd587,   17'd622,   17'd659,   17'd698,
    17'd740,   17'd784,   17'd831,   17'd880,   17'd932,   17'd988,
    17'd1047,  17'd1109,  17'd1175,  17'd1244,  17'd1319,  17'd1397,
    17'd1480,  17'd1568,  17'd1661,  17'd1760,  17'd1864,  17'd1976,
    17'd2093,  17'd2218,  17'd2349,  17'd2490,  17'd2637,  17'd2794,
    17'd2960,  17'd3136,  17'd3323,  17'd3520,  17'd3730,  17'd3950,
    17'd4186,  17'd4435,  17'd4699,  17'd4978,  17'd5274,  17'd5587,
    17'd5920,  17'd6272,  17'd6645,  17'd7040,  17'd7459,  17'd7902,
    17'd8373,  17'd8870,  17'd9397,  17'd9957,  17'd10549, 17'd11176,
    17'd11840, 17'd12544, 17'd13290, 17'd14080, 17'd14917, 17'd15805,
    17'd16752, 17'd17744, 17'd18800, 17'd19920, 17'd21104, 17'd22352,
    17'd23680, 17'd25088, 17'd26576, 17'd28160, 17'd29840, 17'd31616,
    17'd33488, 17'd35472, 17'd37584, 17'd39824, 17'd42192, 17'd44704,
    17'd47360, 17'd50176, 17'd53152, 17'd56320, 17'd59664, 17'd63216,
    17'd66976
  };

  // absolute difference of two frequencies
  function automatic logic [FREQ_W-1:0] abs_diff(input logic [FREQ_W-1:0] a,
                                                 input logic [FREQ_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: design/fnm_if.sv
// fnm_if: valid/ready channel interfaces for frequency items and note results
`timescale 1ns / 1ps

interface fnm_in_if;
  logic                       valid;
  logic                       ready;
  logic [fnm_pkg::FREQ_W-1:0] frequency;

  modport source (output valid, output frequency, input ready);
  modport sink   (input valid, input frequency, output ready);
endinterface

interface fnm_out_if;
  logic                       valid;
  logic                       ready;
  logic                       note_valid;
  logic [fnm_pkg::OCT_W-1:0]  octave;
  logic [fnm_pkg::NOTE_W-1:0] note_index;

  modport source (output valid, output note_valid, output octave, output note_index,
                  input ready);
  modport sink   (input valid, input note_valid, input octave, input note_index,
                  output ready);
endinterface

// File: design/fnm_xmul.sv
// fnm_xmul: shared cross-multiply unit, two registered products and a compare
`timescale 1ns / 1ps

module fnm_xmul (
  input  logic              clk_i,
  input  fnm_pkg::mul_ops_t ops_i,
  output logic              lt_o
);
  import fnm_pkg::*;

  logic [PROD_W-1:0] p0_q, p1_q;

  // both products registered before the compare
  always_ff @(posedge clk_i) begin
    p0_q <= {{FREQ_W{1'b0}}, ops_i.a0} * {{FREQ_W{1'b0}}, ops_i.b0};
    p1_q <= {{FREQ_W{1'b0}}, ops_i.a1} * {{FREQ_W{1'b0}}, ops_i.b1};
  end

  // strict compare of the products from the previous cycle
  assign lt_o = (p0_q < p1_q);

endmodule

// File: design/frequency_to_note_matcher_core.sv
// frequency_to_note_matcher_core: nearest note search over the rom with a shared multiplier
`timescale 1ns / 1ps
//
// Usage: one frequency item (17 bits, 1/16 Hz) enters on in_if, one note result
// leaves on out_if; both channels move an item when valid and ready are high.
// A write port (cfg_we_i, cfg_idx_i, cfg_wdata_i) sets the limits, the noise band
// and the match tolerance; write it only while the block is idle.
// A rejected frequency goes from the check state straight to done. A scanned frequency
// is checked against min(TABLE_ENTRIES, 97) rom entries, the first seeding the best;
// each later entry takes a multiply and a compare state of the shared cross-multiply
// unit (multiply, then compare and update), then a final pair tests the match tolerance.
// Throughput: one item at a time; in_if.ready is high only while no search runs.
// A finished result sits in the output register; if the receiver stalls, a second
// result waits in the sequencer until the register drains, and input stays blocked.
// Reset: asynchronous, active low; clears the sequencer and the output valid and
// loads the register defaults (27.5 Hz to 4186 Hz, noise 40 Hz +- 2 Hz, tolerance 0.1).
//
module frequency_to_note_matcher_core #(
  parameter int unsigned TABLE_ENTRIES = 97
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fnm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fnm_pkg::FREQ_W-1:0]        cfg_wdata_i,
  fnm_in_if.sink                            in_if,
  fnm_out_if.source                         out_if
);
  import fnm_pkg::*;

  localparam int unsigned SCAN_N = (TABLE_ENTRIES < ROM_LEN) ? TABLE_ENTRIES : ROM_LEN;
  localparam int unsigned IDX_W  = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_N - 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_CMP   = 7'b0001000,
    ST_FMUL  = 7'b0010000,
    ST_FCMP  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [FREQ_W-1:0] min_freq_q, max_freq_q, noise_ctr_q;
  logic [NTOL_W-1:0] noise_tol_q;
  logic [MTOL_W-1:0] match_tol_q;

  // search datapath
  logic [FREQ_W-1:0] freq_q;
  logic [IDX_W-1:0]  idx_q;
  logic [OCT_W-1:0]  oct_cnt_q, best_oct_q;
  logic [NOTE_W-1:0] note_cnt_q, best_note_q;
  logic [FREQ_W-1:0] best_d_q, best_t_q;
  logic              match_q;

  // output register
  logic              out_valid_q;
  logic              out_match_q;
  logic [OCT_W-1:0]  out_oct_q;
  logic [NOTE_W-1:0] out_note_q;

  logic [FREQ_W-1:0] rom_val, diff;
  logic              reject, lt, in_fire, out_load;
  mul_ops_t          ops;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_freq_q  <= MIN_FREQ_RST;
      max_freq_q  <= MAX_FREQ_RST;
      noise_ctr_q <= NOISE_CTR_RST;
      noise_tol_q <= NOISE_TOL_RST;
      match_tol_q <= MATCH_TOL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_FREQ:  min_freq_q  <= cfg_wdata_i;
        REG_MAX_FREQ:  max_freq_q  <= cfg_wdata_i;
        REG_NOISE_CTR: noise_ctr_q <= cfg_wdata_i;
        REG_NOISE_TOL: noise_tol_q <= cfg_wdata_i[NTOL_W-1:0];
        REG_MATCH_TOL: match_tol_q <= cfg_wdata_i[MTOL_W-1:0];
        default: ;
      endcase
    end
  end

  // rom entry under test and its distance to the input
  assign rom_val = NOTE_ROM[ROM_IDX_W'(idx_q)];
  assign diff    = abs_diff(freq_q, rom_val);

  // zero, range and noise band rejection
  assign reject = (freq_q == '0) || (freq_q < min_freq_q) || (freq_q > max_freq_q) ||
                  (abs_diff(freq_q, noise_ctr_q) < {{(FREQ_W-NTOL_W){1'b0}}, noise_tol_q});

  // operand select for the shared unit: entry compare or final tolerance test
  always_comb begin
    if (state_q == ST_FMUL) begin
      ops.a0 = best_d_q;
      ops.b0 = MTOL_SCALE;
      ops.a1 = {{(FREQ_W-MTOL_W){1'b0}}, match_tol_q};
      ops.b1 = best_t_q;
    end else begin
      ops.a0 = diff;
      ops.b0 = best_t_q;
      ops.a1 = best_d_q;
      ops.b1 = rom_val;
    end
  end

  fnm_xmul u_xmul (
    .clk_i (clk_i),
    .ops_i (ops),
    .lt_o  (lt)
  );

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_if.ready);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_CHECK;
      ST_CHECK: state_d = reject ? ST_DONE : ST_MUL;
      ST_MUL:   state_d = ST_CMP;
      ST_CMP:   state_d = (idx_q == LAST_IDX) ? ST_FMUL : ST_MUL;
      ST_FMUL:  state_d = ST_FCMP;
      ST_FCMP:  state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // search registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          freq_q <= in_if.frequency;
          idx_q  <= '0;
        end
      end
      ST_CHECK: begin
        // first entry seeds the best candidate
        match_q     <= 1'b0;
        best_d_q    <= diff;
        best_t_q    <= rom_val;
        best_oct_q  <= '0;
        best_note_q <= '0;
        idx_q       <= IDX_W'(1);
        oct_cnt_q   <= '0;
        note_cnt_q  <= NOTE_W'(1);
      end
      ST_CMP: begin
        // smaller relative difference wins, ties keep the earlier entry
        if (lt) begin
          best_d_q    <= diff;
          best_t_q    <= rom_val;
          best_oct_q  <= oct_cnt_q;
          best_note_q <= note_cnt_q;
        end
        idx_q <= idx_q + IDX_W'(1);
        if (note_cnt_q == LAST_NOTE) begin
          note_cnt_q <= '0;
          oct_cnt_q  <= oct_cnt_q + OCT_W'(1);
        end else begin
          note_cnt_q <= note_cnt_q + NOTE_W'(1);
        end
      end
      ST_FCMP: match_q <= lt;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_match_q <= match_q;
      out_oct_q   <= match_q ? best_oct_q : '0;
      out_note_q  <= match_q ? best_note_q : '0;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.note_valid = out_match_q;
  assign out_if.octave     = out_oct_q;
  assign out_if.note_index = out_note_q;

endmodule

// File: dv/tb_frequency_to_note_matcher_core.sv
// tb_frequency_to_note_matcher_core: self-checking testbench for the nearest note matcher
`timescale 1ns / 1ps

module tb_frequency_to_note_matcher_core;
  import fnm_pkg::*;

  localparam int unsigned NOTE_COUNT     = 97;
  localparam int unsigned SEMITONES      = 12;
  localparam int          FREQ_TOP       = 2 ** FREQ_W - 1;
  localparam int unsigned SCAN_CYCLES    = 200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RAND_PHASES    = 13;
  localparam int unsigned PHASE_ITEMS    = 125;
  localparam int unsigned CALM_ITEMS     = 75;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_MATCH_TOL + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  // equal-tempered notes C0 upward, 1/16 Hz units
  localparam logic [FREQ_W-1:0] NOTE_HZ16 [NOTE_COUNT] = '{
    17'd262,   17'd277,   17'd294,   17'd311,   17'd330,   17'd349,
    17'd370,   17'd392,   17'd415,   17'd440,   17'd466,   17'd494,
    17'd523,   17'd554,   17'd587,   17'd622,   17'd659,   17'd698,
    17'd740,   17'd784,   17'd831,   17'd880,   17'd932,   17'd988,
    17'd1047,  17'd1109,  17'd1175,  17'd1244,  17'd1319,  17'd1397,
    17'd1480,  17'd1568,  17'd1661,  17'd1760,  17'd1864,  17'd1976,
    17'd2093,  17'd2218,  17'd2349,  17'd2490,  17'd2637,  17'd2794,
    17'd2960,  17'd3136,  17'd3323,  17'd3520,  17'd3730,  17'd3950,
    17'd4186,  17'd4435,  17'd4699,  17'd4978,  17'd5274,  17'd5587,
    17'd5920,  17'd6272,  17'd6645,  17'd7040,  17'd7459,  17'd7902,
    17'd8373,  17'd8870,  17'd9397,  17'd9957,  17'd10549, 17'd11176,
    17'd11840, 17'd12544, 17'd13290, 17'd14080, 17'd14917, 17'd15805,
    17'd16752, 17'd17744, 17'd18800, 17'd19920, 17'd21104, 17'd22352,
    17'd23680, 17'd25088, 17'd26576, 17'd28160, 17'd29840, 17'd31616,
    17'd33488, 17'd35472, 17'd37584, 17'd39824, 17'd42192, 17'd44704,
    17'd47360, 17'd50176, 17'd53152, 17'd56320, 17'd59664, 17'd63216,
    17'd66976
  };

  typedef struct packed {
    logic              note_valid;
    logic [OCT_W-1:0]  octave;
    logic [NOTE_W-1:0] note_index;
  } note_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [FREQ_W-1:0]    cfg_wdata_i;

  fnm_in_if  in_ch ();
  fnm_out_if out_ch ();

  frequency_to_note_matcher_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  // local copy of the configuration registers
  logic [FREQ_W-1:0] lo_freq;
  logic [FREQ_W-1:0] hi_freq;
  logic [FREQ_W-1:0] noise_ctr;
  logic [NTOL_W-1:0] noise_tol;
  logic [MTOL_W-1:0] match_tol;

  logic [FREQ_W-1:0] freq_backlog [$];
  note_res_t         expected_notes [$];
  int unsigned       issued_count;
  int unsigned       accepted_count;
  int unsigned       fail_count;
  int unsigned       idle_cycles;
  int unsigned       send_gap;
  int unsigned       stall_left;
  logic              calm;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // nearest note by relative distance, earliest entry on a tie
  function automatic note_res_t nearest_note(input logic [FREQ_W-1:0] f);
    note_res_t       res;
    int unsigned     pick;
    int unsigned     i;
    longint unsigned fv;
    longint unsigned t;
    longint unsigned d;
    longint unsigned pick_d;
    longint unsigned pick_t;
    longint unsigned noise_gap;
    res = '0;
    fv = f;
    noise_gap = (fv >= noise_ctr) ? fv - noise_ctr : noise_ctr - fv;
    if (fv == 0 || fv < lo_freq || fv > hi_freq || noise_gap < noise_tol) return res;
    pick = 0;
    pick_t = NOTE_HZ16[0];
    pick_d = (fv >= pick_t) ? fv - pick_t : pick_t - fv;
    for (i = 1; i < NOTE_COUNT; i++) begin
      t = NOTE_HZ16[i];
      d = (fv >= t) ? fv - t : t - fv;
      if (d * pick_t < pick_d * t) begin
        pick = i;
        pick_d = d;
        pick_t = t;
      end
    end
    if ((pick_d << 16) < longint'(match_tol) * pick_t) begin
      res.note_valid = 1'b1;
      res.octave     = OCT_W'(pick / SEMITONES);
      res.note_index = NOTE_W'(pick % SEMITONES);
    end
    return res;
  endfunction

  // register write, mirrored into the local copy once the block has taken it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FREQ_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MIN_FREQ:  lo_freq = val;
      REG_MAX_FREQ:  hi_freq = val;
      REG_NOISE_CTR: noise_ctr = val;
      REG_NOISE_TOL: noise_tol = val[NTOL_W-1:0];
      REG_MATCH_TOL: match_tol = val[MTOL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_freq(input logic [FREQ_W-1:0] f);
    freq_backlog.push_back(f);
    issued_count++;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (accepted_count != issued_count || expected_notes.size() != 0);
  endtask

  // frequency driver, random gaps after an item
  always @(posedge clk_i or negedge rst_ni) begin : drive_freq
    logic              nxt_valid;
    logic [FREQ_W-1:0] nxt_freq;
    if (!rst_ni) begin
      in_ch.valid     <= 1'b0;
      in_ch.frequency <= '0;
      send_gap = 0;
    end else begin
      nxt_valid = in_ch.valid;
      nxt_freq  = in_ch.frequency;
      if (!in_ch.valid || in_ch.ready) begin
        nxt_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (freq_backlog.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_freq  = freq_backlog.pop_front();
          if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 9);
        end
      end
      in_ch.valid     <= nxt_valid;
      in_ch.frequency <= nxt_freq;
    end
  end

  // result receiver, random stall bursts
  always @(posedge clk_i or negedge rst_ni) begin : drive_ready
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
    end
  end

  // monitor: predict on input item, compare on result item, watchdog
  always @(posedge clk_i or negedge rst_ni) begin : check_notes
    note_res_t want;
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_notes.size() == 0) begin
          $error("unexpected result item: note_valid %0d octave %0d note_index %0d",
                 out_ch.note_valid, out_ch.octave, out_ch.note_index);
          fail_count++;
        end else begin
          want = expected_notes.pop_front();
          if (out_ch.note_valid !== want.note_valid) begin
            $error("note_valid: expected %0d, got %0d", want.note_valid, out_ch.note_valid);
            fail_count++;
          end
          if (out_ch.octave !== want.octave) begin
            $error("octave: expected %0d, got %0d", want.octave, out_ch.octave);
            fail_count++;
          end
          if (out_ch.note_index !== want.note_index) begin
            $error("note_index: expected %0d, got %0d", want.note_index, out_ch.note_index);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_notes.push_back(nearest_note(in_ch.frequency));
        accepted_count++;
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // stimulus: directed checks, then random phases with fresh settings
  initial begin : stimulus
    int unsigned       ph;
    int unsigned       k;
    longint            cand;
    longint            base;
    longint            delta;
    longint            span;
    logic [FREQ_W-1:0] v;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    calm            = 1'b0;
    issued_count    = 0;
    accepted_count  = 0;
    fail_count      = 0;
    lo_freq         = 17'd440;
    hi_freq         = 17'd66976;
    noise_ctr       = 17'd640;
    noise_tol       = 12'd32;
    match_tol       = 16'd6554;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: zero, range edges, noise band edges, exact notes
    send_freq(17'd0);
    send_freq(17'd1);
    send_freq(17'd439);
    send_freq(17'd440);
    send_freq(17'd66976);
    send_freq(17'd66977);
    send_freq(17'd131071);
    send_freq(17'd640);
    send_freq(17'd609);
    send_freq(17'd608);
    send_freq(17'd671);
    send_freq(17'd672);
    send_freq(17'd7040);
    send_freq(17'd4186);
    send_freq(17'd453);
    send_freq(17'd30000);
    wait_idle();

    // widest window, no noise band, loosest tolerance; zero still rejected
    write_reg(REG_MIN_FREQ, 17'd0);
    write_reg(REG_MAX_FREQ, 17'd131071);
    write_reg(REG_NOISE_CTR, 17'd0);
    write_reg(REG_NOISE_TOL, 17'd0);
    write_reg(REG_MATCH_TOL, 17'd65535);
    send_freq(17'd0);
    send_freq(17'd1);
    send_freq(17'd100);
    send_freq(17'd131071);
    wait_idle();

    // minimum above maximum, widest noise band, spare index ignored
    write_reg(REG_MIN_FREQ, 17'd131071);
    write_reg(REG_MAX_FREQ, 17'd0);
    write_reg(REG_NOISE_CTR, 17'd131071);
    write_reg(REG_NOISE_TOL, 17'd4095);
    write_reg(REG_MATCH_TOL, 17'd0);
    write_reg(REG_SPARE_FIRST, 17'd1);
    write_reg(REG_SPARE_LAST, 17'd131071);
    send_freq(17'd5000);
    send_freq(17'd131071);
    wait_idle();

    // zero match tolerance on an exact note
    write_reg(REG_MIN_FREQ, 17'd1);
    write_reg(REG_MAX_FREQ, 17'd131071);
    send_freq(17'd7040);
    wait_idle();

    // random phases; the last one runs with no idling
    for (ph = 0; ph <= RAND_PHASES; ph++) begin
      calm = (ph == RAND_PHASES) || ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 4))
        0: v = '0;
        1: v = 17'd440;
        2: v = FREQ_W'($urandom_range(0, FREQ_TOP));
        default: v = FREQ_W'($urandom_range(0, 3000));
      endcase
      write_reg(REG_MIN_FREQ, v);
      case ($urandom_range(0, 3))
        0: v = FREQ_W'(FREQ_TOP);
        1: v = 17'd66976;
        default: v = FREQ_W'($urandom_range(lo_freq, FREQ_TOP));
      endcase
      write_reg(REG_MAX_FREQ, v);
      v = ($urandom_range(0, 1) == 0) ? FREQ_W'($urandom_range(0, FREQ_TOP))
                                      : FREQ_W'($urandom_range(0, 8000));
      write_reg(REG_NOISE_CTR, v);
      case ($urandom_range(0, 2))
        0: v = FREQ_W'($urandom_range(0, FREQ_TOP));
        1: v = FREQ_W'($urandom_range(0, 64));
        default: v = '0;
      endcase
      write_reg(REG_NOISE_TOL, v);
      case ($urandom_range(0, 5))
        0: v = '0;
        1: v = FREQ_W'(FREQ_TOP);
        2: v = 17'd6554;
        3: v = FREQ_W'($urandom_range(0, FREQ_TOP));
        default: v = FREQ_W'($urandom_range(0, 20000));
      endcase
      write_reg(REG_MATCH_TOL, v);
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  FREQ_W'($urandom_range(0, FREQ_TOP)));

      for (k = 0; k < ((ph == RAND_PHASES) ? CALM_ITEMS : PHASE_ITEMS); k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            // around a note, spread scaled to the match tolerance
            base  = NOTE_HZ16[$urandom_range(0, NOTE_COUNT - 1)];
            span  = ((base * longint'(match_tol)) >>> 15) + 2;
            delta = $urandom_range(0, int'(span));
            cand  = ($urandom_range(0, 1) == 0) ? base + delta : base - delta;
          end
          5: cand = $urandom_range(0, FREQ_TOP);
          6: begin
            // around the noise band edges
            base  = noise_ctr;
            delta = $urandom_range(0, int'(noise_tol) + 1);
            cand  = ($urandom_range(0, 1) == 0) ? base + delta : base - delta;
          end
          7: begin
            base  = ($urandom_range(0, 1) == 0) ? longint'(lo_freq) : longint'(hi_freq);
            delta = $urandom_range(0, 4);
            cand  = base + delta - 2;
          end
          8: cand = $urandom_range(0, 600);
          default: cand = NOTE_HZ16[$urandom_range(0, NOTE_COUNT - 1)];
        endcase
        if (cand < 0) cand = 0;
        else if (cand > FREQ_TOP) cand = FREQ_TOP;
        send_freq(FREQ_W'(cand));
      end
      wait_idle();
    end

    repeat (SCAN_CYCLES) @(posedge clk_i);
    if (expected_notes.size() != 0) begin
      $error("%0d result items never arrived", expected_notes.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: filelist.f
design/fnm_pkg.sv
design/fnm_if.sv
design/fnm_xmul.sv
design/frequency_to_note_matcher_core.sv
dv/tb_frequency_to_note_matcher_core.sv
